// ===== rtl/core/spm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_pkg: shared types and constants of the sparse polynomial merge block
// Holds the field widths, command codes and the sequencer state type.
// ----------------------------------------------------------------------------
package spm_pkg;

    localparam int DEG_W       = 8;
    localparam int COEFF_W     = 16;
    localparam int OUT_COEFF_W = 17;
    localparam int TERM_W      = DEG_W + COEFF_W;
    localparam int CMD_W       = 2;
    localparam int S_DATA_W    = 24;
    localparam int M_DATA_W    = 32;

    typedef logic [CMD_W-1:0] cmd_t;

    localparam cmd_t CMD_LOAD_A = 2'd0;
    localparam cmd_t CMD_LOAD_B = 2'd1;
    localparam cmd_t CMD_RUN    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_COMP,
        ST_EMIT
    } state_t;

endpackage

// ===== rtl/core/spm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module spm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/sparse_polynomial_add_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_polynomial_add_merge: sum of two sparse polynomials by merging
// Two term stores are filled by load beats; a run beat merges them in order.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel carries commands. s_tuser selects load into store A, load
// into store B, or run; s_tdata carries the term degree and coefficient. A load
// beat is ignored once its store holds MAX_TERMS terms.
// A run beat starts the merge: terms go out on the master channel in merge
// order, equal degrees summed into one term (a zero sum is still sent), and the
// final term of the run carries m_tlast. A run with both stores empty sends
// nothing. After the final beat both stores are empty again.
// Each result term passes in turn through the store read, the compare and add in
// the shared unit and the output register; a run yields N terms, N up to
// 2*MAX_TERMS. Because of the single read port of each store and the one
// comparator/adder set, the next term is read only once the current result beat
// is taken. s_tready stays low from the run beat until the last result beat is
// taken. When the receiver stalls, the result holds in the output register and
// the sequencer waits. Reset (aresetn low, synchronous) empties both stores and
// drops m_tvalid; store contents are not cleared.
// ----------------------------------------------------------------------------
module sparse_polynomial_add_merge #(
    parameter int MAX_TERMS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Slave channel: command beats.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: [7:0] term_degree, [23:8] term_coeff (signed).
    input  logic [spm_pkg::S_DATA_W-1:0]  s_tdata,
    // s_tuser: [1:0] command.
    input  logic [spm_pkg::CMD_W-1:0]     s_tuser,
    // Master channel: result terms.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: [7:0] out_degree, [24:8] out_coeff (signed), [31:25] zero.
    output logic [spm_pkg::M_DATA_W-1:0]  m_tdata,
    // m_tlast: last_term.
    output logic                          m_tlast
);

    import spm_pkg::*;

    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW = $clog2(MAX_TERMS + 1);

    state_t state_reg, state_next;

    logic [CW-1:0] count_a_reg, count_a_next;
    logic [CW-1:0] count_b_reg, count_b_next;
    logic [CW-1:0] ia_reg, ia_next;
    logic [CW-1:0] ib_reg, ib_next;

    logic                   m_valid_reg, m_valid_next;
    logic [DEG_W-1:0]       out_deg_reg, out_deg_next;
    logic [OUT_COEFF_W-1:0] out_coeff_reg, out_coeff_next;
    logic                   out_last_reg, out_last_next;

    logic              we_a, we_b;
    logic [TERM_W-1:0] wterm;
    logic [TERM_W-1:0] term_a, term_b;

    // Fields of the head terms read from the stores.
    logic [DEG_W-1:0]       deg_a, deg_b;
    logic [OUT_COEFF_W-1:0] c17_a, c17_b, c17_sum;
    logic                   has_a, has_b;
    logic                   take_a, take_b;
    logic [CW-1:0]          ia_adv, ib_adv;

    assign wterm = {s_tdata[DEG_W-1:0], s_tdata[DEG_W +: COEFF_W]};

    spm_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_store_a (
        .aclk  (aclk),
        .we    (we_a),
        .waddr (count_a_reg[AW-1:0]),
        .wdata (wterm),
        .raddr (ia_reg[AW-1:0]),
        .rdata (term_a)
    );

    spm_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_store_b (
        .aclk  (aclk),
        .we    (we_b),
        .waddr (count_b_reg[AW-1:0]),
        .wdata (wterm),
        .raddr (ib_reg[AW-1:0]),
        .rdata (term_b)
    );

    // Shared compare and add unit working on the two head terms.
    assign deg_a   = term_a[TERM_W-1 -: DEG_W];
    assign deg_b   = term_b[TERM_W-1 -: DEG_W];
    assign c17_a   = {term_a[COEFF_W-1], term_a[COEFF_W-1:0]};
    assign c17_b   = {term_b[COEFF_W-1], term_b[COEFF_W-1:0]};
    assign c17_sum = c17_a + c17_b;
    assign has_a   = (ia_reg < count_a_reg);
    assign has_b   = (ib_reg < count_b_reg);

    // A store that still has terms supplies the head when the other is used up,
    // when its degree is higher, or together with the other on a tie.
    assign take_a = has_a && (!has_b || (deg_a >= deg_b));
    assign take_b = has_b && (!has_a || (deg_b >= deg_a));
    assign ia_adv = take_a ? ia_reg + CW'(1) : ia_reg;
    assign ib_adv = take_b ? ib_reg + CW'(1) : ib_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_a_reg <= '0;
            count_b_reg <= '0;
            ia_reg      <= '0;
            ib_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_a_reg <= count_a_next;
            count_b_reg <= count_b_next;
            ia_reg      <= ia_next;
            ib_reg      <= ib_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_deg_reg   <= out_deg_next;
        out_coeff_reg <= out_coeff_next;
        out_last_reg  <= out_last_next;
    end

    always_comb begin
        state_next     = state_reg;
        count_a_next   = count_a_reg;
        count_b_next   = count_b_reg;
        ia_next        = ia_reg;
        ib_next        = ib_reg;
        m_valid_next   = m_valid_reg;
        out_deg_next   = out_deg_reg;
        out_coeff_next = out_coeff_reg;
        out_last_next  = out_last_reg;
        s_tready       = 1'b0;
        we_a           = 1'b0;
        we_b           = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (s_tuser)
                        CMD_LOAD_A: begin
                            if (count_a_reg < CW'(MAX_TERMS)) begin
                                we_a         = 1'b1;
                                count_a_next = count_a_reg + CW'(1);
                            end
                        end
                        CMD_LOAD_B: begin
                            if (count_b_reg < CW'(MAX_TERMS)) begin
                                we_b         = 1'b1;
                                count_b_next = count_b_reg + CW'(1);
                            end
                        end
                        CMD_RUN: begin
                            ia_next = '0;
                            ib_next = '0;
                            if ((count_a_reg != '0) || (count_b_reg != '0)) begin
                                state_next = ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                // The stores read the head entries at ia and ib this cycle.
                state_next = ST_COMP;
            end
            ST_COMP: begin
                out_deg_next   = take_a ? deg_a : deg_b;
                out_coeff_next = (take_a && take_b) ? c17_sum : (take_a ? c17_a : c17_b);
                out_last_next  = (ia_adv >= count_a_reg) && (ib_adv >= count_b_reg);
                m_valid_next   = 1'b1;
                ia_next        = ia_adv;
                ib_next        = ib_adv;
                state_next     = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_tready) begin
                    m_valid_next = 1'b0;
                    if (out_last_reg) begin
                        count_a_next = '0;
                        count_b_next = '0;
                        state_next   = ST_IDLE;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_DATA_W - DEG_W - OUT_COEFF_W){1'b0}}, out_coeff_reg, out_deg_reg};

    // The final beat of a run leaves both stores empty.
    a_last_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (count_a_reg == '0 && count_b_reg == '0))
        else $error("stores not emptied after the final beat");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_a_reg <= CW'(MAX_TERMS)) && (count_b_reg <= CW'(MAX_TERMS)))
        else $error("term count beyond capacity");

    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (ia_reg <= count_a_reg && ib_reg <= count_b_reg))
        else $error("merge index ran past its store");

    a_comp_has_term: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMP) |-> (has_a || has_b))
        else $error("merge step with both stores used up");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("command taken while a result is pending");

endmodule

// ===== test/spm_merge_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_merge_checker: result predictor and scoreboard for the polynomial merge
// Watches both channels of the block. Every load or run beat taken on the
// slave side updates a private copy of the two term stores. A run beat adds
// the two polynomials and queues the sum terms. Every beat on the master side
// is checked field by field against the oldest queued sum term.
// ----------------------------------------------------------------------------
module spm_merge_checker #(
    parameter int MAX_TERMS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [spm_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [spm_pkg::CMD_W-1:0]     s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [spm_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                          m_tlast,
    output int                            mismatches,
    output int                            terms_outstanding
);
    import spm_pkg::*;

    typedef struct {
        logic [DEG_W-1:0]              degree;
        logic signed [OUT_COEFF_W-1:0] coeff;
        logic                          last;
    } sum_term_t;

    logic [DEG_W-1:0]   a_deg   [MAX_TERMS];
    logic [COEFF_W-1:0] a_coeff [MAX_TERMS];
    logic [DEG_W-1:0]   b_deg   [MAX_TERMS];
    logic [COEFF_W-1:0] b_coeff [MAX_TERMS];
    int                 a_fill;
    int                 b_fill;
    sum_term_t          sum_terms_due[$];

    initial begin
        mismatches        = 0;
        terms_outstanding = 0;
        a_fill            = 0;
        b_fill            = 0;
    end

    function automatic void push_term(input logic [DEG_W-1:0] degree,
                                      input logic [OUT_COEFF_W-1:0] coeff);
        sum_term_t t;
        t.degree = degree;
        t.coeff  = coeff;
        t.last   = 1'b0;
        sum_terms_due.push_back(t);
    endfunction

    // Walks both stores from the front, comparing only the two head terms,
    // so out-of-order loads are merged by the same rule as sorted ones.
    function automatic void sum_polynomials();
        int ia;
        int ib;
        int first;
        ia    = 0;
        ib    = 0;
        first = sum_terms_due.size();
        while (ia < a_fill && ib < b_fill) begin
            if (a_deg[ia] == b_deg[ib]) begin
                push_term(a_deg[ia], {a_coeff[ia][COEFF_W-1], a_coeff[ia]}
                                   + {b_coeff[ib][COEFF_W-1], b_coeff[ib]});
                ia++;
                ib++;
            end else if (a_deg[ia] > b_deg[ib]) begin
                push_term(a_deg[ia], {a_coeff[ia][COEFF_W-1], a_coeff[ia]});
                ia++;
            end else begin
                push_term(b_deg[ib], {b_coeff[ib][COEFF_W-1], b_coeff[ib]});
                ib++;
            end
        end
        for (; ia < a_fill; ia++) begin
            push_term(a_deg[ia], {a_coeff[ia][COEFF_W-1], a_coeff[ia]});
        end
        for (; ib < b_fill; ib++) begin
            push_term(b_deg[ib], {b_coeff[ib][COEFF_W-1], b_coeff[ib]});
        end
        if (sum_terms_due.size() > first) begin
            sum_terms_due[sum_terms_due.size() - 1].last = 1'b1;
        end
        a_fill = 0;
        b_fill = 0;
    endfunction

    always @(posedge aclk) begin : watch
        sum_term_t                     want;
        logic signed [OUT_COEFF_W-1:0] got_coeff;
        logic [DEG_W-1:0]              got_deg;
        logic [M_DATA_W-1:0]           got_pad;
        if (!aresetn) begin
            a_fill = 0;
            b_fill = 0;
            sum_terms_due.delete();
        end else begin
            // Results are checked before new beats are predicted, so a run taken
            // in the same cycle as a final result queues behind it.
            if (m_tvalid && m_tready) begin
                got_deg   = m_tdata[DEG_W-1:0];
                got_coeff = m_tdata[DEG_W +: OUT_COEFF_W];
                got_pad   = m_tdata >> (DEG_W + OUT_COEFF_W);
                if (sum_terms_due.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected result beat: degree %0d coeff %0d last %0b",
                                 got_deg, got_coeff, m_tlast);
                    end
                    mismatches++;
                end else begin
                    want = sum_terms_due.pop_front();
                    if (got_deg !== want.degree || got_coeff !== want.coeff
                            || m_tlast !== want.last || got_pad !== '0) begin
                        if (mismatches < 10) begin
                            $display({"result mismatch: expected degree %0d coeff %0d last %0b,",
                                      " got degree %0d coeff %0d last %0b pad %0h"},
                                     want.degree, want.coeff, want.last,
                                     got_deg, got_coeff, m_tlast, got_pad);
                        end
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    CMD_LOAD_A: begin
                        if (a_fill < MAX_TERMS) begin
                            a_deg[a_fill]   = s_tdata[DEG_W-1:0];
                            a_coeff[a_fill] = s_tdata[DEG_W +: COEFF_W];
                            a_fill++;
                        end
                    end
                    CMD_LOAD_B: begin
                        if (b_fill < MAX_TERMS) begin
                            b_deg[b_fill]   = s_tdata[DEG_W-1:0];
                            b_coeff[b_fill] = s_tdata[DEG_W +: COEFF_W];
                            b_fill++;
                        end
                    end
                    CMD_RUN: sum_polynomials();
                    default: ;
                endcase
            end
        end
        terms_outstanding = sum_terms_due.size();
    end

endmodule

// ===== test/tb_sparse_polynomial_add_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_polynomial_add_merge: stimulus and verdict for the merge block
// Drives load and run beats into the block while a checker beside it predicts
// every sum term and compares it with what comes out. A short directed list
// covers field extremes, every command, zero sums, out-of-order loads and empty
// runs; random sequences follow, mostly sorted polynomials with shared degrees,
// plus noise and store overflow, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_sparse_polynomial_add_merge;
    import spm_pkg::*;

    localparam int   MAX_TERMS      = 32;
    localparam int   ITEM_TARGET    = 420;
    localparam int   CYCLE_LIMIT    = 400000;
    localparam int   RX_HOLD_CYCLES = 300;
    localparam int   DRAIN_CYCLES   = 30;
    // The fourth command code has no function in the block.
    localparam cmd_t CMD_NOP        = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [CMD_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;

    int                    mismatches;
    int                    terms_outstanding;
    int                    items_sent;
    int                    fill_a;
    int                    fill_b;
    int                    cycle_count;
    bit                    steady_flow;
    bit                    rx_hold_req;

    // Terms of the next polynomial pair, built before any of them is sent.
    logic [DEG_W-1:0]      qa_deg[$];
    logic [COEFF_W-1:0]    qa_co[$];
    logic [DEG_W-1:0]      qb_deg[$];
    logic [COEFF_W-1:0]    qb_co[$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sparse_polynomial_add_merge #(
        .MAX_TERMS(MAX_TERMS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    spm_merge_checker #(
        .MAX_TERMS(MAX_TERMS)
    ) checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tlast          (m_tlast),
        .mismatches       (mismatches),
        .terms_outstanding(terms_outstanding)
    );

    // Coefficients lean on the extremes so that sums reach both ends of the
    // 17-bit result range; the rest are uniform over all 16 bits.
    function automatic logic [COEFF_W-1:0] pick_coeff();
        int r;
        r = $urandom_range(99);
        if (r < 8) return 16'h8000;
        if (r < 16) return 16'h7FFF;
        if (r < 20) return 16'h0000;
        return COEFF_W'($urandom);
    endfunction

    // Presents one beat, called and returning at a falling edge. The valid line
    // either stays high straight into the next beat or drops for a random gap,
    // so it is never lowered and raised within one time step.
    task automatic issue(input cmd_t cmd, input logic [DEG_W-1:0] degree,
                         input logic [COEFF_W-1:0] coeff);
        int gap;
        gap = 0;
        if (!steady_flow && $urandom_range(99) < 25) gap = $urandom_range(1, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {coeff, degree};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        // Only beats that change something count toward the item target.
        if (cmd == CMD_LOAD_A && fill_a < MAX_TERMS) begin
            fill_a++;
            items_sent++;
        end else if (cmd == CMD_LOAD_B && fill_b < MAX_TERMS) begin
            fill_b++;
            items_sent++;
        end else if (cmd == CMD_RUN) begin
            fill_a = 0;
            fill_b = 0;
            items_sent++;
        end
    endtask

    // Drops valid and holds the sender until every predicted term has come out.
    // At least one falling edge passes, so the next beat starts in a later step.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (terms_outstanding != 0) @(negedge aclk);
    endtask

    // Sends the queued A and B terms in a random interleaving, then a run beat
    // with random payload bits, which the block must not care about.
    task automatic load_and_run();
        bit take_a;
        while (qa_deg.size() + qb_deg.size() > 0) begin
            take_a = (qb_deg.size() == 0) || (qa_deg.size() != 0 && $urandom_range(1) == 1);
            if (take_a) issue(CMD_LOAD_A, qa_deg.pop_front(), qa_co.pop_front());
            else        issue(CMD_LOAD_B, qb_deg.pop_front(), qb_co.pop_front());
        end
        issue(CMD_RUN, DEG_W'($urandom), COEFF_W'($urandom));
    endtask

    // Receiver: takes results at random, or steadily during the steady stretch.
    // On request it refuses results for a long counted stretch, so that a run
    // backs up in the block and the slave side stalls behind it.
    initial begin : receiver
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge aclk);
            end
            m_tready <= steady_flow || ($urandom_range(99) >= 25);
        end
    end

    // Watchdog: a run that is still going at the limit has lost results or hung.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[sparse_polynomial_add_merge] ERROR");
        $finish;
    end

    initial begin : stimulus
        int       seq_no;
        int       kind;
        int       n;
        int       span;
        int       top_deg;
        int       d;
        bit       in_a;
        bit       in_b;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = CMD_LOAD_A;
        aresetn     = 1'b0;
        steady_flow = 1'b0;
        rx_hold_req = 1'b0;
        items_sent  = 0;
        fill_a      = 0;
        fill_b      = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part.
        // A run with both stores empty must produce nothing, and so must the
        // unused command, even with every payload bit set.
        issue(CMD_RUN, 8'd0, 16'h0000);
        issue(CMD_NOP, 8'hFF, 16'hFFFF);
        // Extremes: the most negative and most positive sums, a term present
        // only in B, and equal terms that cancel to a zero sum at degree 0.
        issue(CMD_LOAD_A, 8'd255, 16'h8000);
        issue(CMD_LOAD_A, 8'd128, 16'h7FFF);
        issue(CMD_LOAD_A, 8'd0,   16'h0001);
        issue(CMD_LOAD_B, 8'd255, 16'h8000);
        issue(CMD_LOAD_B, 8'd128, 16'h7FFF);
        issue(CMD_LOAD_B, 8'd7,   16'hFFFB);
        issue(CMD_LOAD_B, 8'd0,   16'hFFFF);
        issue(CMD_RUN, 8'd0, 16'h0000);
        // Loads out of order, with a repeated degree in B.
        issue(CMD_LOAD_A, 8'd3,  16'h0001);
        issue(CMD_LOAD_A, 8'd10, 16'h0002);
        issue(CMD_LOAD_B, 8'd5,  16'h0003);
        issue(CMD_LOAD_B, 8'd5,  16'hFFFC);
        issue(CMD_RUN, 8'd0, 16'h0000);
        // Only A holds terms, then only B.
        issue(CMD_LOAD_A, 8'd200, 16'h0064);
        issue(CMD_RUN, 8'd0, 16'h0000);
        issue(CMD_LOAD_B, 8'd1, 16'hFFF9);
        issue(CMD_LOAD_B, 8'd0, 16'h0000);
        issue(CMD_RUN, 8'd0, 16'h0000);
        // After a run both stores are empty again, so this run is silent too.
        issue(CMD_NOP, 8'd0, 16'h0000);
        issue(CMD_RUN, 8'hFF, 16'hFFFF);
        wait_for_results();

        // Random part, one polynomial pair per sequence.
        seq_no = 0;
        while (items_sent < ITEM_TARGET) begin
            steady_flow = (seq_no >= 16 && seq_no < 24);
            if (seq_no == 8) rx_hold_req = 1'b1;
            if (seq_no == 28) wait_for_results();
            kind = $urandom_range(99);
            if (seq_no == 0 || kind >= 96) begin
                // Both stores overfilled: the loads past capacity are dropped.
                n = $urandom_range(MAX_TERMS + 1, MAX_TERMS + 4);
                repeat (n) begin
                    qa_deg.push_back(DEG_W'($urandom));
                    qa_co.push_back(pick_coeff());
                end
                n = $urandom_range(MAX_TERMS + 1, MAX_TERMS + 4);
                repeat (n) begin
                    qb_deg.push_back(DEG_W'($urandom));
                    qb_co.push_back(pick_coeff());
                end
                load_and_run();
            end else if (kind < 78) begin
                // Sorted pair drawn from one window of degrees, so that many
                // degrees appear in both and get summed. Mostly narrow windows
                // give short runs; a wide one now and then fills the stores.
                span    = ($urandom_range(3) == 0) ? $urandom_range(16, 64)
                                                   : $urandom_range(1, 12);
                top_deg = $urandom_range(255, span - 1);
                for (d = top_deg; d > top_deg - span; d--) begin
                    in_a = ($urandom_range(1) == 1) && qa_deg.size() < MAX_TERMS;
                    in_b = ($urandom_range(1) == 1) && qb_deg.size() < MAX_TERMS;
                    if (in_a) begin
                        qa_deg.push_back(DEG_W'(d));
                        qa_co.push_back(pick_coeff());
                    end
                    if (in_b) begin
                        qb_deg.push_back(DEG_W'(d));
                        // A cancelling pair gives a zero sum that still comes out.
                        if (in_a && $urandom_range(2) == 0) begin
                            qb_co.push_back(COEFF_W'(0 - qa_co[qa_co.size() - 1]));
                        end else begin
                            qb_co.push_back(pick_coeff());
                        end
                    end
                end
                load_and_run();
            end else if (kind < 88) begin
                // Unordered terms, often from a tiny degree range so that heads
                // collide; either store may stay empty.
                n = $urandom_range(0, 6);
                repeat (n) begin
                    qa_deg.push_back(($urandom_range(1) == 1) ? DEG_W'($urandom_range(0, 7))
                                                              : DEG_W'($urandom));
                    qa_co.push_back(pick_coeff());
                end
                n = $urandom_range(0, 6);
                repeat (n) begin
                    qb_deg.push_back(($urandom_range(1) == 1) ? DEG_W'($urandom_range(0, 7))
                                                              : DEG_W'($urandom));
                    qb_co.push_back(pick_coeff());
                end
                load_and_run();
            end else begin
                // Noise: an unused command, a run on empty stores, or a stray
                // load that ends up in the next sequence's merge.
                case ($urandom_range(2))
                    0: issue(CMD_NOP, DEG_W'($urandom), COEFF_W'($urandom));
                    1: issue(CMD_RUN, DEG_W'($urandom), COEFF_W'($urandom));
                    default: begin
                        issue(($urandom_range(1) == 1) ? CMD_LOAD_A : CMD_LOAD_B,
                              DEG_W'($urandom), pick_coeff());
                    end
                endcase
            end
            seq_no++;
        end

        // Let the last run finish, then allow a few more cycles for any stray
        // beat the block might still put out.
        steady_flow = 1'b0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0) begin
            $display("[sparse_polynomial_add_merge] OK");
        end else begin
            $display("[sparse_polynomial_add_merge] ERROR");
        end
        $finish;
    end

endmodule
